// File: rtl/core/b58pc_pkg.sv
// Package for the base-58 permuted id codec: field widths, keys, pipeline types
// and the alphabet lookups. Used by every module under rtl/core.
// Depends on nothing.
package b58pc_pkg;

  // Selector carried in tuser
  localparam logic KIND_ENC = 1'b0;  // number to string
  localparam logic KIND_DEC = 1'b1;  // string to number

  localparam int unsigned NumDigits = 6;
  localparam int unsigned NumNibbles = 9;  // covers the 34-bit encode value

  localparam logic [31:0] KEY_XOR = 32'd177451812;
  localparam logic [33:0] KEY_ADD = 34'd8728348608;

  // Divide by 58 for x < 2^14: q = (x * 9040) >> 19, exact in that range
  localparam logic [13:0] DIV58_MUL = 14'd9040;
  localparam int unsigned DIV58_SHIFT = 19;
  localparam logic [5:0] RADIX = 6'd58;

  // Powers of 58, digit weights
  localparam logic [29:0] P58 [NumDigits] = '{
    30'd1, 30'd58, 30'd3364, 30'd195112, 30'd11316496, 30'd656356768
  };

  typedef logic [5:0][5:0] dig_vec_t;   // one base-58 digit per column
  typedef logic [5:0][9:0] prod_vec_t;  // nibble times digit, per column

  // Stage 1: encode value and weighted decode terms
  typedef struct packed {
    logic             kind;
    logic [33:0]      val;
    logic [5:0][35:0] term;
  } in_stage_t;

  // Stages 2..8: column sums with carry, output chars, decode accumulators
  typedef struct packed {
    logic             kind;
    logic [5:0][12:0] col;
    logic [8:0]       cy;
    logic [5:0][6:0]  chr;
    logic [2:0][35:0] acc;
  } pipe_t;

  function automatic logic [5:0] char2dig(logic [6:0] c);
    logic [7:0] cc;
    logic [5:0] d;
    cc = {1'b0, c};
    case (cc)
      "f": d = 6'd0;   "Z": d = 6'd1;   "o": d = 6'd2;   "d": d = 6'd3;
      "R": d = 6'd4;   "9": d = 6'd5;   "X": d = 6'd6;   "Q": d = 6'd7;
      "D": d = 6'd8;   "S": d = 6'd9;   "U": d = 6'd10;  "m": d = 6'd11;
      "2": d = 6'd12;  "1": d = 6'd13;  "y": d = 6'd14;  "C": d = 6'd15;
      "k": d = 6'd16;  "r": d = 6'd17;  "6": d = 6'd18;  "z": d = 6'd19;
      "B": d = 6'd20;  "q": d = 6'd21;  "i": d = 6'd22;  "v": d = 6'd23;
      "e": d = 6'd24;  "Y": d = 6'd25;  "a": d = 6'd26;  "h": d = 6'd27;
      "8": d = 6'd28;  "b": d = 6'd29;  "t": d = 6'd30;  "4": d = 6'd31;
      "x": d = 6'd32;  "s": d = 6'd33;  "W": d = 6'd34;  "p": d = 6'd35;
      "H": d = 6'd36;  "n": d = 6'd37;  "J": d = 6'd38;  "E": d = 6'd39;
      "7": d = 6'd40;  "j": d = 6'd41;  "L": d = 6'd42;  "5": d = 6'd43;
      "V": d = 6'd44;  "G": d = 6'd45;  "3": d = 6'd46;  "g": d = 6'd47;
      "u": d = 6'd48;  "M": d = 6'd49;  "T": d = 6'd50;  "K": d = 6'd51;
      "N": d = 6'd52;  "P": d = 6'd53;  "A": d = 6'd54;  "w": d = 6'd55;
      "c": d = 6'd56;  "F": d = 6'd57;
      default: d = 6'd0;  // not in the alphabet: same digit as 'f'
    endcase
    return d;
  endfunction

  function automatic logic [6:0] dig2char(logic [5:0] d);
    logic [7:0] cc;
    case (d)
      6'd0:  cc = "f";  6'd1:  cc = "Z";  6'd2:  cc = "o";  6'd3:  cc = "d";
      6'd4:  cc = "R";  6'd5:  cc = "9";  6'd6:  cc = "X";  6'd7:  cc = "Q";
      6'd8:  cc = "D";  6'd9:  cc = "S";  6'd10: cc = "U";  6'd11: cc = "m";
      6'd12: cc = "2";  6'd13: cc = "1";  6'd14: cc = "y";  6'd15: cc = "C";
      6'd16: cc = "k";  6'd17: cc = "r";  6'd18: cc = "6";  6'd19: cc = "z";
      6'd20: cc = "B";  6'd21: cc = "q";  6'd22: cc = "i";  6'd23: cc = "v";
      6'd24: cc = "e";  6'd25: cc = "Y";  6'd26: cc = "a";  6'd27: cc = "h";
      6'd28: cc = "8";  6'd29: cc = "b";  6'd30: cc = "t";  6'd31: cc = "4";
      6'd32: cc = "x";  6'd33: cc = "s";  6'd34: cc = "W";  6'd35: cc = "p";
      6'd36: cc = "H";  6'd37: cc = "n";  6'd38: cc = "J";  6'd39: cc = "E";
      6'd40: cc = "7";  6'd41: cc = "j";  6'd42: cc = "L";  6'd43: cc = "5";
      6'd44: cc = "V";  6'd45: cc = "G";  6'd46: cc = "3";  6'd47: cc = "g";
      6'd48: cc = "u";  6'd49: cc = "M";  6'd50: cc = "T";  6'd51: cc = "K";
      6'd52: cc = "N";  6'd53: cc = "P";  6'd54: cc = "A";  6'd55: cc = "w";
      6'd56: cc = "c";  6'd57: cc = "F";
      default: cc = 8'd0;
    endcase
    return cc[6:0];
  endfunction

endpackage

// File: rtl/core/b58pc_enc_lane.sv
// Encode lane: one 4-bit slice of the value times the base-58 digits of its
// place weight. Depends on b58pc_pkg.
module b58pc_enc_lane
  import b58pc_pkg::*;
(
  input  logic [3:0] nib_i,
  input  dig_vec_t   wgt_i,
  output prod_vec_t  prod_o
);

  always_comb begin
    for (int j = 0; j < NumDigits; j++) begin
      prod_o[j] = 10'(nib_i) * 10'(wgt_i[j]);
    end
  end

endmodule

// File: rtl/core/b58pc_dec_lane.sv
// Decode lane: one character to its digit, weighted by its power of 58.
// Depends on b58pc_pkg.
module b58pc_dec_lane
  import b58pc_pkg::*;
(
  input  logic [6:0]  chr_i,
  input  logic [29:0] wgt_i,
  output logic [35:0] term_o
);

  logic [5:0] dig;

  assign dig    = char2dig(chr_i);
  assign term_o = 36'(dig) * 36'(wgt_i);

endmodule

// File: rtl/core/b58pc_carry.sv
// Carry cell: folds the incoming carry into one column and splits it into
// a base-58 digit and the carry for the next column. Depends on b58pc_pkg.
module b58pc_carry
  import b58pc_pkg::*;
(
  input  logic [12:0] col_i,
  input  logic [8:0]  cy_i,
  output logic [5:0]  dig_o,
  output logic [8:0]  cy_o
);

  logic [13:0] x;
  logic [27:0] prod;
  logic [8:0]  quo;
  logic [13:0] rem;

  always_comb begin
    x     = 14'(col_i) + 14'(cy_i);
    prod  = 28'(x) * 28'(DIV58_MUL);   // reciprocal multiply, exact for 14 bits
    quo   = prod[DIV58_SHIFT +: 9];
    rem   = x - 14'(18'(quo) * 18'(RADIX));
    dig_o = rem[5:0];
    cy_o  = quo;
  end

endmodule

// File: rtl/core/id_base58_permuted_codec.sv
// Top level of the base-58 permuted id codec: lanes, column merge and the
// pipeline control. Depends on b58pc_pkg, b58pc_enc_lane, b58pc_dec_lane, b58pc_carry.
//
//  channel  | dir | tdata (low bit up)                           | tuser
//  ---------+-----+----------------------------------------------+---------
//  s_axis   | in  | av_number, in_char_0 .. in_char_5, pad to 80 | kind
//  m_axis   | out | out_char_0 .. out_char_5, decoded_number,    | -
//           |     | pad to 80                                    |
//
// One item per cycle while the output is not stalled. The depth is
// set by the six-stage carry chain that turns column sums into base-58 digits.
// rst_ni clears only the stage valid bits; payload registers are not reset.
// The whole pipe stalls while the last stage holds an item that is not taken,
// so s_axis_tready_o = !last valid || m_axis_tready_i.
module id_base58_permuted_codec
  import b58pc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,   // av_number[31:0], in_char_0..5 (7b each), pad
  input  logic        s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o    // out_char_0..5 (7b each), decoded_number[35:0], pad
);

  localparam int unsigned LastStage = 8;

  logic [LastStage:1] vld_q;
  logic               adv;

  in_stage_t in_d, in_q;
  pipe_t     pipe_d [2:LastStage];
  pipe_t     pipe_q [2:LastStage];

  // Global advance: the pipe moves unless the output item is held.
  assign adv             = !vld_q[LastStage] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[LastStage];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LastStage-1:1], s_axis_tvalid_i};
    end
  end

  // ---- Stage 1: key mix for encode, decode lanes -----------------------------
  logic [5:0][35:0] dec_term;

  for (genvar i = 0; i < NumDigits; i++) begin : g_dec_lane
    b58pc_dec_lane u_dec_lane (
      .chr_i  (s_axis_tdata_i[32 + 7*i +: 7]),
      .wgt_i  (P58[i]),
      .term_o (dec_term[i])
    );
  end

  always_comb begin
    in_d.kind = s_axis_tuser_i;
    in_d.val  = 34'(s_axis_tdata_i[31:0] ^ KEY_XOR) + KEY_ADD;
    in_d.term = dec_term;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_d;
    end
  end

  // ---- Stage 2: nibble lanes and column sums, first decode add ---------------
  prod_vec_t lane_prod [NumNibbles];

  for (genvar k = 0; k < NumNibbles; k++) begin : g_enc_lane
    dig_vec_t   wgt;
    logic [3:0] nib;

    // Base-58 digits of 16^k, worked out at elaboration
    for (genvar j = 0; j < NumDigits; j++) begin : g_wgt
      localparam logic [5:0] WgtDig = 6'(((64'd1 << (4 * k)) / 64'(P58[j])) % 64'd58);
      assign wgt[j] = WgtDig;
    end

    if (4 * k + 4 <= 34) begin : g_full
      assign nib = in_q.val[4*k +: 4];
    end else begin : g_part
      assign nib = 4'(in_q.val[33:4*k]);
    end

    b58pc_enc_lane u_enc_lane (
      .nib_i  (nib),
      .wgt_i  (wgt),
      .prod_o (lane_prod[k])
    );
  end

  always_comb begin
    pipe_d[2].kind = in_q.kind;
    pipe_d[2].cy   = '0;
    pipe_d[2].chr  = '0;
    for (int j = 0; j < NumDigits; j++) begin
      pipe_d[2].col[j] = '0;
      for (int k = 0; k < NumNibbles; k++) begin
        pipe_d[2].col[j] = pipe_d[2].col[j] + 13'(lane_prod[k][j]);
      end
    end
    pipe_d[2].acc[0] = in_q.term[0] + in_q.term[1];
    pipe_d[2].acc[1] = in_q.term[2] + in_q.term[3];
    pipe_d[2].acc[2] = in_q.term[4] + in_q.term[5];
  end

  // ---- Stages 3..8: one carry column each; decode finishes alongside ---------
  for (genvar s = 3; s <= LastStage; s++) begin : g_stage
    localparam int unsigned Col = s - 3;
    logic [5:0] dig;
    logic [8:0] cy;

    b58pc_carry u_carry (
      .col_i (pipe_q[s-1].col[Col]),
      .cy_i  (pipe_q[s-1].cy),
      .dig_o (dig),
      .cy_o  (cy)
    );

    always_comb begin
      pipe_d[s]          = pipe_q[s-1];
      pipe_d[s].cy       = cy;
      pipe_d[s].chr[Col] = (pipe_q[s-1].kind == KIND_DEC) ? 7'd0 : dig2char(dig);
      if (s == 3) begin
        pipe_d[s].acc[0] = pipe_q[s-1].acc[0] + pipe_q[s-1].acc[1];
      end else if (s == 4) begin
        pipe_d[s].acc[0] = pipe_q[s-1].acc[0] + pipe_q[s-1].acc[2];
      end else if (s == 5) begin
        // total minus offset, then key; negative differences wrap in 36 bits
        pipe_d[s].acc[0] = (pipe_q[s-1].kind == KIND_DEC) ?
                           ((pipe_q[s-1].acc[0] - 36'(KEY_ADD)) ^ 36'(KEY_XOR)) : 36'd0;
      end
    end
  end

  for (genvar s = 2; s <= LastStage; s++) begin : g_pipe_reg
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pipe_q[s] <= pipe_d[s];
      end
    end
  end

  assign m_axis_tdata_o = {2'b00, pipe_q[LastStage].acc[0], pipe_q[LastStage].chr};

endmodule

// File: test/id_codec_checker.sv
// Scoreboard for the base-58 permuted id codec: watches both stream channels,
// predicts each result on its own and compares it field by field.
// Depends on b58pc_pkg for the kind codes.
module id_codec_checker
  import b58pc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [79:0] s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [79:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [63:0] XOR_KEY = 64'd177451812;
  localparam logic [63:0] ADD_KEY = 64'd8728348608;
  localparam logic [8*58-1:0] ALPHABET =
    "fZodR9XQDSUm21yCkr6zBqiveYah8bt4xsWpHnJE7jL5VG3guMTKNPAwcF";

  typedef struct packed {
    logic [5:0][6:0] chr;
    logic [35:0]     number;
  } id_result_t;

  id_result_t expected_ids[$];

  function automatic logic [6:0] alpha_char(int unsigned d);
    return ALPHABET[8*(57-d) +: 7];
  endfunction

  // Anything outside the alphabet reads as digit zero
  function automatic int unsigned char_digit(logic [6:0] c);
    for (int unsigned i = 0; i < 58; i++) begin
      if (alpha_char(i) == c) return i;
    end
    return 0;
  endfunction

  function automatic id_result_t convert_id(logic kind, logic [31:0] av,
                                            logic [5:0][6:0] ch);
    id_result_t r;
    logic [63:0] v;
    logic [63:0] w;
    r = '0;
    if (kind == KIND_ENC) begin
      v = {32'd0, av} ^ XOR_KEY;
      v = v + ADD_KEY;
      for (int i = 0; i < 6; i++) begin
        r.chr[i] = alpha_char(32'(v % 58));
        v = v / 58;
      end
    end else begin
      v = '0;
      w = 64'd1;
      for (int i = 0; i < 6; i++) begin
        v = v + char_digit(ch[i]) * w;
        w = w * 58;
      end
      v = (v - ADD_KEY) ^ XOR_KEY;
      r.number = v[35:0];
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    id_result_t want;
    id_result_t got;
    if (!rst_ni) begin
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        expected_ids.push_back(convert_id(s_tuser_i, s_tdata_i[31:0], s_tdata_i[73:32]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got.chr = m_tdata_i[41:0];
        got.number = m_tdata_i[77:42];
        if (expected_ids.size() == 0) begin
          $error("result item with nothing outstanding: tdata %0h", m_tdata_i);
          fail_count_o++;
        end else begin
          want = expected_ids.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (got.chr[i] !== want.chr[i]) begin
              $error("out_char_%0d: expected %0h, got %0h", i, want.chr[i], got.chr[i]);
              fail_count_o++;
            end
          end
          if (got.number !== want.number) begin
            $error("decoded_number: expected %0h, got %0h", want.number, got.number);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_ids.size();
    end
  end

endmodule

// File: test/id_base58_permuted_codec_test.sv
// Testbench top for the base-58 permuted id codec: clock, reset, stimulus with
// bursty sender and stalling receiver, and the verdict.
// Depends on b58pc_pkg, id_base58_permuted_codec and id_codec_checker.
module id_base58_permuted_codec_test;
  import b58pc_pkg::*;

  localparam logic [8*58-1:0] ALPHABET =
    "fZodR9XQDSUm21yCkr6zBqiveYah8bt4xsWpHnJE7jL5VG3guMTKNPAwcF";
  localparam int RANDOM_ITEMS = 1030;
  localparam int DRAIN_CYCLES = 16;  // pipe is 8 deep, leave margin

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tuser = KIND_ENC;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  int          fail_count;
  int          pending;

  int          burst_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  id_base58_permuted_codec dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  id_codec_checker checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Receiver: a stall mode is picked for a random stretch of cycles.
  // 0 = always ready, 1 = coin flip, 2 = mostly stalled, 3 = hard stall.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = (stall_mode == 3) ? $urandom_range(2, 12) : $urandom_range(16, 96);
    end
    mode_left--;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 5) == 0);
      default: m_tready <= 1'b0;
    endcase
  end

  function automatic logic [5:0][6:0] valid_chars();
    logic [5:0][6:0] ch;
    for (int i = 0; i < 6; i++) ch[i] = ALPHABET[8*(57-$urandom_range(0, 57)) +: 7];
    return ch;
  endfunction

  // Six-character literal, leftmost character is in_char_0
  function automatic logic [5:0][6:0] chars_of(logic [47:0] s);
    logic [5:0][6:0] ch;
    for (int i = 0; i < 6; i++) ch[i] = s[8*(5-i) +: 7];
    return ch;
  endfunction

  // Holds the item on the bus until it is taken; returns on the accepting edge.
  // tready is looked at on the falling edge, where it is settled.
  task automatic send_id(logic kind, logic [31:0] av, logic [5:0][6:0] ch);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {6'd0, ch, av};
    @(negedge clk_i);
    while (!s_tready) @(negedge clk_i);
    @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // burst over: a gap, then a new burst (sometimes a long one without gaps)
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Sender holds off until every outstanding result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int sel;
    logic [31:0] av;
    logic [5:0][6:0] ch;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Encode extremes; av equal to the xor key gives the bare offset
    send_id(KIND_ENC, 32'h0000_0000, valid_chars());
    send_id(KIND_ENC, 32'hFFFF_FFFF, '1);
    send_id(KIND_ENC, 32'd177451812, '0);
    send_id(KIND_ENC, 32'h8000_0000, valid_chars());
    send_id(KIND_ENC, 32'hAAAA_AAAA, valid_chars());
    send_id(KIND_ENC, 32'h5555_5555, valid_chars());
    send_id(KIND_ENC, 32'd170001, valid_chars());
    // Decode: a known good string, all lowest digits (negative result),
    // all highest digits, and characters outside the alphabet
    send_id(KIND_DEC, $urandom, chars_of("CK7wx1"));
    send_id(KIND_DEC, 32'h0, chars_of("ffffff"));
    send_id(KIND_DEC, 32'hFFFF_FFFF, chars_of("FFFFFF"));
    send_id(KIND_DEC, $urandom, '0);
    send_id(KIND_DEC, $urandom, '1);
    send_id(KIND_DEC, $urandom, chars_of("CK7wx "));
    send_id(KIND_DEC, $urandom, chars_of("0OIl+_"));
    send_id(KIND_DEC, $urandom, chars_of("ZZZZZZ"));
    send_id(KIND_DEC, $urandom, chars_of("fffffF"));
    send_id(KIND_DEC, $urandom, chars_of("Ffffff"));
    send_id(KIND_DEC, $urandom, chars_of("A2wc5b"));
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        av = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 255)
                                                                  : $urandom_range(0, 255))
                                         : $urandom;
        ch = 42'({$urandom, $urandom});
        send_id(KIND_ENC, av, ch);
      end else if (sel < 85) begin
        send_id(KIND_DEC, $urandom, valid_chars());
      end else begin
        // mostly valid string with some arbitrary 7-bit codes mixed in
        ch = valid_chars();
        for (int i = 0; i < 6; i++) begin
          if ($urandom_range(0, 2) == 0) ch[i] = 7'($urandom_range(0, 127));
        end
        send_id(KIND_DEC, $urandom, ch);
      end
      if (n == RANDOM_ITEMS / 2) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
rtl/core/b58pc_pkg.sv
rtl/core/b58pc_enc_lane.sv
rtl/core/b58pc_dec_lane.sv
rtl/core/b58pc_carry.sv
rtl/core/id_base58_permuted_codec.sv
test/id_codec_checker.sv
test/id_base58_permuted_codec_test.sv
